### rtl/nsh_pkg.sv
// Shared types and constants for the nearest sphere hit block.
`timescale 1ns / 1ps
package nsh_pkg;

    localparam int MAX_SPHERES = 16;
    localparam int SLOT_W      = $clog2(MAX_SPHERES);
    localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

    localparam int ACC_W   = 52;   // a, h, c sums
    localparam int MUL_W   = 34;   // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int CHUNK_W = 25;   // split of wide operands for the discriminant
    localparam int E_W     = 101;  // h*h - a*c
    localparam int RAD_W   = 102;  // discriminant, 4*(h*h - a*c)
    localparam int ROOT_W  = RAD_W / 2;
    localparam int NUM_W   = 53;   // positive numerator
    localparam int DEN_W   = 49;   // 2*a
    localparam int SD_W    = 80;   // shared subtractor width
    localparam int T_W     = 31;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 6;

    localparam logic [T_W-1:0] NEAR_EPS = T_W'(66);
    localparam logic [T_W-1:0] T_MAX    = {T_W{1'b1}};

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RAY  = 1'b1;

    localparam int  PADDR_W    = 3;
    localparam logic REG_ACTIVE = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_OC,
        ST_PMUL,
        ST_PACC,
        ST_CHKA,
        ST_EMUL,
        ST_EACC,
        ST_CHKD,
        ST_SQRT,
        ST_ROOT1,
        ST_DIV1,
        ST_ROOT2,
        ST_DIV2,
        ST_NEXT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_sd_req;

endpackage

### rtl/nsh_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module nsh_mul (
    input  logic                                i_clk,
    input  logic signed [nsh_pkg::MUL_W-1:0]    i_a,
    input  logic signed [nsh_pkg::MUL_W-1:0]    i_b,
    output logic signed [nsh_pkg::PROD_W-1:0]   o_p
);

    logic signed [nsh_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### rtl/nsh_sqdiv.sv
// Iterative square root and fractional divider sharing one subtractor.
`timescale 1ns / 1ps
module nsh_sqdiv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nsh_pkg::t_sd_req                i_req,
    input  logic [nsh_pkg::RAD_W-1:0]       i_rad,
    input  logic [nsh_pkg::NUM_W-1:0]       i_num,
    input  logic [nsh_pkg::DEN_W-1:0]       i_den,
    output logic                            o_done,
    output logic [nsh_pkg::ROOT_W-1:0]      o_root,
    output logic [nsh_pkg::T_W-1:0]         o_quot
);

    localparam int W = nsh_pkg::SD_W;

    logic                           r_busy;
    logic                           r_done;
    logic                           r_div;
    logic [nsh_pkg::STEP_W-1:0]     r_cnt;
    logic                           r_sat;
    logic [W-1:0]                   r_rem;
    logic [nsh_pkg::RAD_W-1:0]      r_opnd;
    logic [nsh_pkg::ROOT_W-1:0]     r_acc;

    logic [W-1:0] rem_sh;
    logic [W-1:0] trial;
    logic [W-1:0] lhs;
    logic [W-1:0] rhs;
    logic [W:0]   diff;
    logic         ge;

    assign rem_sh = {r_rem[W-3:0], r_opnd[nsh_pkg::RAD_W-1 -: 2]};
    assign trial  = {{(W - nsh_pkg::ROOT_W - 2){1'b0}}, r_acc, 2'b01};
    assign lhs    = r_div ? r_rem : rem_sh;
    assign rhs    = r_div ? r_opnd[W-1:0] : trial;
    assign diff   = {1'b0, lhs} - {1'b0, rhs};
    assign ge     = ~diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.is_div;
                r_cnt  <= i_req.is_div ? nsh_pkg::STEP_W'(nsh_pkg::DIV_STEPS - 1)
                                       : nsh_pkg::STEP_W'(nsh_pkg::SQRT_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: restoring steps, one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_sat <= 1'b0;
            if (i_req.is_div) begin
                r_rem  <= {{(W - nsh_pkg::NUM_W - 16){1'b0}}, i_num, 16'b0};
                r_opnd <= {{(nsh_pkg::RAD_W - nsh_pkg::DEN_W - 31){1'b0}}, i_den, 31'b0};
            end else begin
                r_rem  <= '0;
                r_opnd <= i_rad;
            end
        end else if (r_busy) begin
            r_acc <= {r_acc[nsh_pkg::ROOT_W-2:0], ge};
            if (r_div) begin
                r_rem  <= ge ? diff[W-1:0] : r_rem;
                r_opnd <= r_opnd >> 1;
                // quotient bit 31 set: beyond the 31-bit range
                if (r_cnt == nsh_pkg::STEP_W'(nsh_pkg::DIV_STEPS - 1) && ge) begin
                    r_sat <= 1'b1;
                end
            end else begin
                r_rem  <= ge ? diff[W-1:0] : rem_sh;
                r_opnd <= r_opnd << 2;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_acc;
    assign o_quot = r_sat ? nsh_pkg::T_MAX : r_acc[nsh_pkg::T_W-1:0];

endmodule

### rtl/nearest_sphere_hit.sv
// Top level: sphere table, ray sequencer and nearest hit tracking.
// Load request: written to the table when taken, no result.
// Ray request: per active sphere, up to 18 multiplier passes, the 51-step square root and up to
// two 32-step quotients; a sphere with zero a ends after its a, h and c products.
// One request at a time; the next is taken the cycle after the result enters the output register.
// Reset (synchronous, active low) clears control and active_spheres; the table is not cleared.
`timescale 1ns / 1ps
module nearest_sphere_hit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_func,
    input  logic [nsh_pkg::SLOT_W-1:0]          i_sphere_slot,
    input  logic signed [31:0]                  i_center_x,
    input  logic signed [31:0]                  i_center_y,
    input  logic signed [31:0]                  i_center_z,
    input  logic [30:0]                         i_sphere_radius,
    input  logic signed [31:0]                  i_origin_x,
    input  logic signed [31:0]                  i_origin_y,
    input  logic signed [31:0]                  i_origin_z,
    input  logic signed [31:0]                  i_dir_x,
    input  logic signed [31:0]                  i_dir_y,
    input  logic signed [31:0]                  i_dir_z,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [nsh_pkg::SLOT_W-1:0]          o_hit_slot,
    output logic [nsh_pkg::T_W-1:0]             o_hit_distance,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nsh_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AW    = nsh_pkg::ACC_W;
    localparam int MUL_W = nsh_pkg::MUL_W;

    // sphere table, one entry per slot, no reset value
    logic [31:0] mem_cx [nsh_pkg::MAX_SPHERES];
    logic [31:0] mem_cy [nsh_pkg::MAX_SPHERES];
    logic [31:0] mem_cz [nsh_pkg::MAX_SPHERES];
    logic [30:0] mem_r  [nsh_pkg::MAX_SPHERES];

    nsh_pkg::t_state r_state, n_state;

    logic [nsh_pkg::CNT_W-1:0]  r_active;
    logic [nsh_pkg::CNT_W-1:0]  r_n;
    logic [nsh_pkg::CNT_W-1:0]  r_s;
    logic [3:0]                 r_k;

    logic signed [31:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [30:0]        r_r;
    logic signed [32:0] r_ocx, r_ocy, r_ocz;
    logic signed [AW-1:0] r_a, r_h, r_c;
    logic signed [nsh_pkg::E_W-1:0] r_e;
    logic [nsh_pkg::ROOT_W-1:0] r_sq;

    logic                       r_found;
    logic [nsh_pkg::T_W-1:0]    r_best;
    logic [nsh_pkg::SLOT_W-1:0] r_slot;

    logic                       r_out_valid;
    logic                       r_hit;
    logic [nsh_pkg::SLOT_W-1:0] r_hit_slot;
    logic [nsh_pkg::T_W-1:0]    r_hit_dist;

    logic in_acc, out_free, cfg_wr;
    logic signed [nsh_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [nsh_pkg::PROD_W-1:0] prod;
    nsh_pkg::t_sd_req           sd_req;
    logic                       sd_done;
    logic [nsh_pkg::ROOT_W-1:0] sd_root;
    logic [nsh_pkg::T_W-1:0]    sd_quot;
    logic [nsh_pkg::NUM_W-1:0]  sd_num;

    // magnitudes and chunks for the discriminant products
    logic [AW-1:0] h_mag, c_mag;
    logic [nsh_pkg::CHUNK_W-1:0] hl, hh, al, ah, cl, ch;
    logic [nsh_pkg::E_W-1:0] pp, pp_sh;
    logic signed [AW-1:0] qv;

    // roots: num = -2h -/+ sq
    logic signed [nsh_pkg::NUM_W:0] nb, sqx, num1, num2;
    logic pos1, pos2;
    logic better;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign h_mag = r_h[AW-1] ? -r_h : r_h;
    assign c_mag = r_c[AW-1] ? -r_c : r_c;
    assign hl = h_mag[nsh_pkg::CHUNK_W-1:0];
    assign hh = h_mag[2*nsh_pkg::CHUNK_W-1:nsh_pkg::CHUNK_W];
    assign al = r_a[nsh_pkg::CHUNK_W-1:0];
    assign ah = r_a[2*nsh_pkg::CHUNK_W-1:nsh_pkg::CHUNK_W];
    assign cl = c_mag[nsh_pkg::CHUNK_W-1:0];
    assign ch = c_mag[2*nsh_pkg::CHUNK_W-1:nsh_pkg::CHUNK_W];

    assign qv = prod[nsh_pkg::PROD_W-1:16];
    assign pp = {{(nsh_pkg::E_W - 2*nsh_pkg::CHUNK_W){1'b0}},
                 prod[2*nsh_pkg::CHUNK_W-1:0]};

    assign nb   = -{{2{r_h[AW-1]}}, r_h[AW-2:0], 1'b0};
    assign sqx  = {{(nsh_pkg::NUM_W + 1 - nsh_pkg::ROOT_W){1'b0}}, r_sq};
    assign num1 = nb - sqx;
    assign num2 = nb + sqx;
    assign pos1 = !num1[nsh_pkg::NUM_W] && (num1 != '0);
    assign pos2 = !num2[nsh_pkg::NUM_W] && (num2 != '0);
    assign sd_num = (r_state == nsh_pkg::ST_ROOT1) ? num1[nsh_pkg::NUM_W-1:0]
                                                   : num2[nsh_pkg::NUM_W-1:0];
    assign better = (sd_quot > nsh_pkg::NEAR_EPS) && (!r_found || sd_quot < r_best);

    // shift of a discriminant partial product by chunk position
    always_comb begin
        case (r_k)
            4'd0, 4'd4: pp_sh = pp;
            4'd3, 4'd7: pp_sh = pp << (2 * nsh_pkg::CHUNK_W);
            default:    pp_sh = pp << nsh_pkg::CHUNK_W;
        endcase
    end

    nsh_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    nsh_sqdiv u_sqdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .i_rad   ({r_e[nsh_pkg::RAD_W-3:0], 2'b00}),
        .i_num   (sd_num),
        .i_den   ({r_a[nsh_pkg::DEN_W-2:0], 1'b0}),
        .o_done  (sd_done),
        .o_root  (sd_root),
        .o_quot  (sd_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, multiplier operands, unit requests
    always_comb begin
        n_state       = r_state;
        mul_a         = '0;
        mul_b         = '0;
        sd_req.start  = 1'b0;
        sd_req.is_div = 1'b0;
        case (r_state)
            nsh_pkg::ST_IDLE: begin
                if (in_acc && i_func == nsh_pkg::FUNC_RAY) begin
                    n_state = (i_func == nsh_pkg::FUNC_RAY && r_active == '0)
                              ? nsh_pkg::ST_OUT : nsh_pkg::ST_RD;
                end
            end
            nsh_pkg::ST_RD:   n_state = nsh_pkg::ST_OC;
            nsh_pkg::ST_OC:   n_state = nsh_pkg::ST_PMUL;
            nsh_pkg::ST_PMUL: begin
                case (r_k)
                    4'd0: begin mul_a = MUL_W'(r_dx);  mul_b = MUL_W'(r_dx);  end
                    4'd1: begin mul_a = MUL_W'(r_dy);  mul_b = MUL_W'(r_dy);  end
                    4'd2: begin mul_a = MUL_W'(r_dz);  mul_b = MUL_W'(r_dz);  end
                    4'd3: begin mul_a = MUL_W'(r_ocx); mul_b = MUL_W'(r_dx);  end
                    4'd4: begin mul_a = MUL_W'(r_ocy); mul_b = MUL_W'(r_dy);  end
                    4'd5: begin mul_a = MUL_W'(r_ocz); mul_b = MUL_W'(r_dz);  end
                    4'd6: begin mul_a = MUL_W'(r_ocx); mul_b = MUL_W'(r_ocx); end
                    4'd7: begin mul_a = MUL_W'(r_ocy); mul_b = MUL_W'(r_ocy); end
                    4'd8: begin mul_a = MUL_W'(r_ocz); mul_b = MUL_W'(r_ocz); end
                    default: begin
                        mul_a = {3'b0, r_r};
                        mul_b = {3'b0, r_r};
                    end
                endcase
                n_state = nsh_pkg::ST_PACC;
            end
            nsh_pkg::ST_PACC: begin
                n_state = (r_k == 4'd9) ? nsh_pkg::ST_CHKA : nsh_pkg::ST_PMUL;
            end
            nsh_pkg::ST_CHKA: begin
                n_state = (r_a == '0) ? nsh_pkg::ST_NEXT : nsh_pkg::ST_EMUL;
            end
            nsh_pkg::ST_EMUL: begin
                case (r_k)
                    4'd0: begin mul_a = MUL_W'(hl); mul_b = MUL_W'(hl); end
                    4'd1: begin mul_a = MUL_W'(hl); mul_b = MUL_W'(hh); end
                    4'd2: begin mul_a = MUL_W'(hh); mul_b = MUL_W'(hl); end
                    4'd3: begin mul_a = MUL_W'(hh); mul_b = MUL_W'(hh); end
                    4'd4: begin mul_a = MUL_W'(al); mul_b = MUL_W'(cl); end
                    4'd5: begin mul_a = MUL_W'(al); mul_b = MUL_W'(ch); end
                    4'd6: begin mul_a = MUL_W'(ah); mul_b = MUL_W'(cl); end
                    default: begin mul_a = MUL_W'(ah); mul_b = MUL_W'(ch); end
                endcase
                n_state = nsh_pkg::ST_EACC;
            end
            nsh_pkg::ST_EACC: begin
                n_state = (r_k == 4'd7) ? nsh_pkg::ST_CHKD : nsh_pkg::ST_EMUL;
            end
            nsh_pkg::ST_CHKD: begin
                // negative discriminant: miss
                if (r_e[nsh_pkg::E_W-1]) begin
                    n_state = nsh_pkg::ST_NEXT;
                end else begin
                    sd_req.start = 1'b1;
                    n_state      = nsh_pkg::ST_SQRT;
                end
            end
            nsh_pkg::ST_SQRT: begin
                if (sd_done) n_state = nsh_pkg::ST_ROOT1;
            end
            nsh_pkg::ST_ROOT1: begin
                if (pos1) begin
                    sd_req.start  = 1'b1;
                    sd_req.is_div = 1'b1;
                    n_state       = nsh_pkg::ST_DIV1;
                end else begin
                    n_state = nsh_pkg::ST_ROOT2;
                end
            end
            nsh_pkg::ST_DIV1: begin
                if (sd_done) begin
                    n_state = (sd_quot > nsh_pkg::NEAR_EPS) ? nsh_pkg::ST_NEXT
                                                            : nsh_pkg::ST_ROOT2;
                end
            end
            nsh_pkg::ST_ROOT2: begin
                if (pos2) begin
                    sd_req.start  = 1'b1;
                    sd_req.is_div = 1'b1;
                    n_state       = nsh_pkg::ST_DIV2;
                end else begin
                    n_state = nsh_pkg::ST_NEXT;
                end
            end
            nsh_pkg::ST_DIV2: begin
                if (sd_done) n_state = nsh_pkg::ST_NEXT;
            end
            nsh_pkg::ST_NEXT: begin
                n_state = (r_s + 1'b1 == r_n) ? nsh_pkg::ST_OUT : nsh_pkg::ST_RD;
            end
            nsh_pkg::ST_OUT: begin
                if (out_free) n_state = nsh_pkg::ST_IDLE;
            end
            default: n_state = nsh_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_s         <= '0;
            r_n         <= '0;
            r_k         <= '0;
        end else begin
            // configuration: only the active count is writable
            if (cfg_wr && paddr[2] == nsh_pkg::REG_ACTIVE) begin
                r_active <= pwdata[nsh_pkg::CNT_W-1:0];
            end
            // drop the result once taken, load a new one in ST_OUT
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (r_state == nsh_pkg::ST_OUT && out_free) r_out_valid <= 1'b1;

            case (r_state)
                nsh_pkg::ST_IDLE: begin
                    if (in_acc && i_func == nsh_pkg::FUNC_RAY) begin
                        r_found <= 1'b0;
                        r_s     <= '0;
                        r_n     <= (r_active > nsh_pkg::CNT_W'(nsh_pkg::MAX_SPHERES))
                                   ? nsh_pkg::CNT_W'(nsh_pkg::MAX_SPHERES) : r_active;
                    end
                end
                nsh_pkg::ST_OC:   r_k <= '0;
                nsh_pkg::ST_PACC: r_k <= (r_k == 4'd9) ? 4'd0 : r_k + 1'b1;
                nsh_pkg::ST_EACC: r_k <= r_k + 1'b1;
                nsh_pkg::ST_DIV1, nsh_pkg::ST_DIV2: begin
                    if (sd_done && better) r_found <= 1'b1;
                end
                nsh_pkg::ST_NEXT: r_s <= r_s + 1'b1;
                default: ;
            endcase
        end
    end

    // table writes and payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            nsh_pkg::ST_IDLE: begin
                if (in_acc && i_func == nsh_pkg::FUNC_LOAD) begin
                    mem_cx[i_sphere_slot] <= i_center_x;
                    mem_cy[i_sphere_slot] <= i_center_y;
                    mem_cz[i_sphere_slot] <= i_center_z;
                    mem_r[i_sphere_slot]  <= i_sphere_radius;
                end
                if (in_acc) begin
                    r_ox <= i_origin_x;
                    r_oy <= i_origin_y;
                    r_oz <= i_origin_z;
                    r_dx <= i_dir_x;
                    r_dy <= i_dir_y;
                    r_dz <= i_dir_z;
                    r_best <= '0;
                    r_slot <= '0;
                end
            end
            nsh_pkg::ST_RD: begin
                r_cx <= mem_cx[r_s[nsh_pkg::SLOT_W-1:0]];
                r_cy <= mem_cy[r_s[nsh_pkg::SLOT_W-1:0]];
                r_cz <= mem_cz[r_s[nsh_pkg::SLOT_W-1:0]];
                r_r  <= mem_r[r_s[nsh_pkg::SLOT_W-1:0]];
            end
            nsh_pkg::ST_OC: begin
                r_ocx <= {r_ox[31], r_ox} - {r_cx[31], r_cx};
                r_ocy <= {r_oy[31], r_oy} - {r_cy[31], r_cy};
                r_ocz <= {r_oz[31], r_oz} - {r_cz[31], r_cz};
                r_a   <= '0;
                r_h   <= '0;
                r_c   <= '0;
            end
            nsh_pkg::ST_PACC: begin
                // product floored to Q16.16 by the arithmetic shift
                if (r_k < 4'd3)       r_a <= r_a + qv;
                else if (r_k < 4'd6)  r_h <= r_h + qv;
                else if (r_k < 4'd9)  r_c <= r_c + qv;
                else                  r_c <= r_c - qv;
            end
            nsh_pkg::ST_CHKA: r_e <= '0;
            nsh_pkg::ST_EACC: begin
                // h*h terms add; a*c terms are subtracted, so they add when c is negative
                if (r_k < 4'd4 || r_c[AW-1]) r_e <= r_e + $signed(pp_sh);
                else                         r_e <= r_e - $signed(pp_sh);
            end
            nsh_pkg::ST_SQRT: begin
                if (sd_done) r_sq <= sd_root;
            end
            nsh_pkg::ST_DIV1, nsh_pkg::ST_DIV2: begin
                if (sd_done && better) begin
                    r_best <= sd_quot;
                    r_slot <= r_s[nsh_pkg::SLOT_W-1:0];
                end
            end
            nsh_pkg::ST_OUT: begin
                if (out_free) begin
                    r_hit      <= r_found;
                    r_hit_slot <= r_found ? r_slot : '0;
                    r_hit_dist <= r_found ? r_best : '0;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall     = (r_state != nsh_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_slot     = r_hit_slot;
    assign o_hit_distance = r_hit_dist;
    assign pready         = 1'b1;
    assign prdata         = (paddr[2] == nsh_pkg::REG_ACTIVE)
                            ? {{(32 - nsh_pkg::CNT_W){1'b0}}, r_active} : 32'd0;

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sd_done |-> (r_state == nsh_pkg::ST_SQRT || r_state == nsh_pkg::ST_DIV1 ||
                     r_state == nsh_pkg::ST_DIV2))
        else $error("root/divide unit finished outside a wait state");

    // a miss reports zero slot and distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit) |-> (r_hit_slot == '0 && r_hit_dist == '0))
        else $error("miss with non-zero slot or distance");

    // a hit always lies beyond the epsilon
    a_hit_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_hit) |-> (r_hit_dist > nsh_pkg::NEAR_EPS))
        else $error("hit distance not beyond epsilon");

    // sphere index stays inside the active count whenever a table entry is read
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsh_pkg::ST_RD) |-> (r_s < r_n))
        else $error("sphere index beyond the active count");

endmodule
